### rtl/core/xbm_pkg.sv
// ----------------------------------------------------------------------------
// xbm_pkg
// Types and constants shared by the bitmap pixel expander modules.
// ----------------------------------------------------------------------------
package xbm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // Width used for size comparisons; holds any width or height limit up to 1024.
  localparam int DIM_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COLOR   = 3'd4;

  localparam logic [8:0]  WIDTH_RESET  = 9'd8;
  localparam logic [8:0]  HEIGHT_RESET = 9'd8;
  localparam logic [15:0] COLOR_RESET  = 16'h94ac;

  typedef struct packed {
    logic [7:0] bitmap_byte;
    logic       first_of_image;
  } xbm_in_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [15:0]        draw_color;
    logic               last_of_byte;
    logic               last_of_image;
  } xbm_out_t;

  // One classified byte waiting for expansion.
  typedef struct packed {
    logic [7:0]  byte_mask;
    logic [15:0] base_x;
    logic [15:0] pixel_y;
    logic [15:0] color;
    logic        last_img;
  } xbm_job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } xbm_q_stat_t;

endpackage

### rtl/core/xbm_front.sv
// ----------------------------------------------------------------------------
// xbm_front
// Holds the configuration and the bitmap position; classifies each accepted
// byte and hands bytes with set bits that fall inside the image to the queue.
// ----------------------------------------------------------------------------
module xbm_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [xbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  xbm_pkg::xbm_in_t                item,
  output logic                            enq,
  output xbm_pkg::xbm_job_t               job
);
  import xbm_pkg::*;

  localparam int MAX_STRIDE = (MAX_WIDTH + 7) / 8;
  localparam int COL_W      = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [8:0]         bitmap_width;
  logic [8:0]         bitmap_height;
  logic [15:0]        pixel_color;

  logic [COL_W-1:0]   byte_column;
  logic [ROW_W-1:0]   pixel_row;
  logic               image_done;

  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic               done_cur;
  logic [DIM_W-1:0]   w_ext, h_ext, w_eff, h_eff, stride;
  logic               skip, last_col, last_img;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      bitmap_width  <= WIDTH_RESET;
      bitmap_height <= HEIGHT_RESET;
      pixel_color   <= COLOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X:      origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      origin_y      <= cfg_data;
        CFG_BITMAP_WIDTH:  bitmap_width  <= cfg_data[8:0];
        CFG_BITMAP_HEIGHT: bitmap_height <= cfg_data[8:0];
        CFG_PIXEL_COLOR:   pixel_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_cur  = item.first_of_image ? '0 : byte_column;
    row_cur  = item.first_of_image ? '0 : pixel_row;
    done_cur = item.first_of_image ? 1'b0 : image_done;

    w_ext  = DIM_W'(bitmap_width);
    h_ext  = DIM_W'(bitmap_height);
    w_eff  = (w_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_ext;
    h_eff  = (h_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_ext;
    stride = (w_eff + DIM_W'(7)) >> 3;

    skip     = done_cur || (stride == '0) || (h_eff == '0);
    last_col = (DIM_W'(col_cur) + DIM_W'(1)) >= stride;
    last_img = last_col && ((DIM_W'(row_cur) + DIM_W'(1)) >= h_eff);

    enq = accept && !skip && (item.bitmap_byte != '0);

    job.byte_mask = item.bitmap_byte;
    job.base_x    = 16'({col_cur, 3'b000}) + $unsigned(origin_x);
    job.pixel_y   = 16'(row_cur) + $unsigned(origin_y);
    job.color     = pixel_color;
    job.last_img  = last_img;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      pixel_row   <= '0;
      image_done  <= 1'b0;
    end else if (accept) begin
      byte_column <= col_cur;
      pixel_row   <= row_cur;
      image_done  <= done_cur;
      if (!skip) begin
        if (last_img) begin
          image_done <= 1'b1;
        end else if (last_col) begin
          byte_column <= '0;
          pixel_row   <= row_cur + ROW_W'(1);
        end else begin
          byte_column <= col_cur + COL_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/xbm_queue.sv
// ----------------------------------------------------------------------------
// xbm_queue
// Two-entry queue of classified bytes between the front and the back end.
// ----------------------------------------------------------------------------
module xbm_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  xbm_pkg::xbm_job_t      wr_job,
  input  logic                   rd,
  output xbm_pkg::xbm_job_t      head,
  output xbm_pkg::xbm_q_stat_t   stat
);
  import xbm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  xbm_job_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && stat.valid;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/xbm_back.sv
// ----------------------------------------------------------------------------
// xbm_back
// Expands one queued byte into pixel writes, lowest set bit first, one
// pixel per transfer on the result side.
// ----------------------------------------------------------------------------
module xbm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  xbm_pkg::xbm_q_stat_t   q_stat,
  input  xbm_pkg::xbm_job_t      head,
  output logic                   deq,
  input  logic                   pop,
  output logic                   empty,
  output xbm_pkg::xbm_out_t      result
);
  import xbm_pkg::*;

  xbm_job_t   job;
  logic [7:0] mask;
  logic [7:0] rest;
  logic [2:0] bit_idx;
  logic       active, take, load;

  function automatic logic [2:0] low_index(input logic [7:0] m);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  always_comb begin
    active  = (mask != '0);
    rest    = mask & (mask - 8'd1);
    bit_idx = low_index(mask);
    take    = pop && active;
    // The working register refills when it is idle or its last pixel leaves.
    load    = q_stat.valid && (!active || (take && (rest == '0)));
    deq     = load;
    empty   = !active;

    result.pixel_x       = job.base_x + 16'(bit_idx);
    result.pixel_y       = job.pixel_y;
    result.draw_color    = job.color;
    result.last_of_byte  = (rest == '0);
    result.last_of_image = job.last_img;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= head.byte_mask;
    end else if (take) begin
      mask <= rest;
    end
  end

endmodule

### rtl/core/xbm_bitmap_pixel_expander_top.sv
// ----------------------------------------------------------------------------
// xbm_bitmap_pixel_expander_top
// Expands a row-major monochrome bitmap, one byte per transfer, into
// coloured pixel writes at the configured origin.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the two-entry job queue has room; the
// result side gives one pixel per cycle while pop is high, so a byte with k
// set bits gives k pixels (1 to 8) and a zero byte is not queued at all.
// The sustained rate is set by that one-pixel-per-cycle emitter, loading the
// next queued byte as the last pixel of one leaves. There is no start-up sweep;
// the block takes bytes right after reset. cfg_ready is always high.
module xbm_bitmap_pixel_expander_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  xbm_pkg::xbm_in_t                item,
  output logic                            empty,
  input  logic                            pop,
  output xbm_pkg::xbm_out_t               result
);
  import xbm_pkg::*;

  logic        accept;
  logic        enq, deq;
  xbm_job_t    job, head;
  xbm_q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;
  assign accept    = push && !full;

  xbm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .enq       (enq),
    .job       (job)
  );

  xbm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (enq),
    .wr_job (job),
    .rd     (deq),
    .head   (head),
    .stat   (q_stat)
  );

  xbm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (head),
    .deq    (deq),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // A byte that still has pixels to give keeps the result side busy.
  a_byte_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_of_byte) |=> !empty)
    else $error("result side went empty in the middle of a byte");

  // Pixels of one byte share a row.
  a_same_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_of_byte) |=> (result.pixel_y == $past(result.pixel_y)))
    else $error("row changed within one byte");

  // The front never offers a job to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(enq && q_stat.full))
    else $error("job written into a full queue");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap pixel expander. Bitmap bytes are pushed
// through the input queue port, and each byte's pixel writes are predicted in
// the bench and compared field by field with what comes out of the result
// queue. Directed bytes cover the special cases. Random images then run under
// three idle patterns and occasional long output stalls.
// ----------------------------------------------------------------------------
module tb;
  import xbm_pkg::*;

  localparam int MAX_W      = 256;
  localparam int MAX_H      = 256;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_LEN   = 80;
  localparam int DRAIN_WAIT = 12;
  localparam int PHASE_ITEMS = 130;
  localparam int MAX_IMAGE_BYTES = 64;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  xbm_in_t               item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  xbm_out_t              result;

  // Bytes waiting to be offered, and the pixel writes still owed by the block.
  xbm_in_t  bytes_to_send[$];
  xbm_out_t expected_pixels[$];

  // Bench copy of the registers and of the scan position.
  logic [15:0] org_x, org_y, color;
  logic [8:0]  bm_w, bm_h;
  int          pos_col, pos_row;
  bit          img_done;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int next_hold_at = 100;
  int holds_done = 0;
  int quiet_cycles = 0;
  int err_count = 0;
  int bytes_accepted = 0;
  int bytes_ignored = 0;
  int images_started = 0;
  int pixels_checked = 0;
  int reg_writes = 0;

  xbm_bitmap_pixel_expander_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_count++;
    if (err_count <= 30) begin
      $display("tb: mismatch on %s at pixel %0d: got %h, want %h",
               what, pixels_checked, got, want);
    end
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    reg_writes++;
    case (idx)
      CFG_ORIGIN_X:      org_x = data;
      CFG_ORIGIN_Y:      org_y = data;
      CFG_BITMAP_WIDTH:  bm_w  = data[8:0];
      CFG_BITMAP_HEIGHT: bm_h  = data[8:0];
      CFG_PIXEL_COLOR:   color = data;
      default: ;
    endcase
  endtask

  // Works out the pixel writes one bitmap byte causes and moves the position.
  task automatic expand_byte(input xbm_in_t it);
    int       w, h, stride;
    bit       last_col, last_img;
    xbm_out_t px;
    if (it.first_of_image) begin
      pos_col  = 0;
      pos_row  = 0;
      img_done = 1'b0;
      images_started++;
    end
    w = (bm_w > MAX_W) ? MAX_W : int'(bm_w);
    h = (bm_h > MAX_H) ? MAX_H : int'(bm_h);
    stride = (w + 7) / 8;
    if (img_done || stride == 0 || h == 0) begin
      bytes_ignored++;
      return;
    end
    // A register change mid-image can leave the position past the new size.
    last_col = (pos_col + 1 >= stride);
    last_img = last_col && (pos_row + 1 >= h);
    for (int j = 0; j < 8; j++) begin
      if (it.bitmap_byte[j]) begin
        px.pixel_x       = 16'(pos_col * 8 + j + int'(org_x));
        px.pixel_y       = 16'(pos_row + int'(org_y));
        px.draw_color    = color;
        px.last_of_byte  = ((it.bitmap_byte >> (j + 1)) == 8'd0);
        px.last_of_image = last_img;
        expected_pixels.push_back(px);
      end
    end
    if (last_img) begin
      img_done = 1'b1;
    end else if (last_col) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col++;
    end
  endtask

  // Driver: offers the oldest pending byte and tracks every accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      org_x    = '0;
      org_y    = '0;
      bm_w     = WIDTH_RESET;
      bm_h     = HEIGHT_RESET;
      color    = COLOR_RESET;
      pos_col  = 0;
      pos_row  = 0;
      img_done = 1'b0;
    end else begin
      if (push && !full) begin
        expand_byte(item);
        void'(bytes_to_send.pop_front());
        bytes_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
      end
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
        push <= 1'b1;
        item <= bytes_to_send[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pops results, checks them, and now and then holds off for a
  // long stretch while bytes are still queued so that the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel, x", result.pixel_x, 16'h0000);
        end else begin
          xbm_out_t want;
          want = expected_pixels.pop_front();
          if (result.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", result.pixel_x, want.pixel_x);
          if (result.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", result.pixel_y, want.pixel_y);
          if (result.draw_color !== want.draw_color)
            report_mismatch("draw_color", result.draw_color, want.draw_color);
          if (result.last_of_byte !== want.last_of_byte)
            report_mismatch("last_of_byte", 16'(result.last_of_byte),
                            16'(want.last_of_byte));
          if (result.last_of_image !== want.last_of_image)
            report_mismatch("last_of_image", 16'(result.last_of_image),
                            16'(want.last_of_image));
        end
        pixels_checked++;
      end
      if (hold_left == 0 && pixels_checked >= next_hold_at && bytes_to_send.size() > 4) begin
        hold_left = HOLD_LEN;
        next_hold_at += 500;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("tb: timeout, no transfer for %0d cycles", QUIET_MAX);
        $display("tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic xbm_in_t mk_byte(input logic [7:0] b, input logic first);
    xbm_in_t it;
    it.bitmap_byte    = b;
    it.first_of_image = first;
    return it;
  endfunction

  // Mostly ordinary content, with plenty of empty, full and single-bit bytes.
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 25) return 8'hFF;
    if (r < 35) return 8'h01 << $urandom_range(7);
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_origin();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h7FFF;
    if (r < 20) return 16'h8000;
    if (r < 25) return 16'hFFFF;
    if (r < 30) return 16'h0000;
    return 16'($urandom);
  endfunction

  // Called between transfers at a falling edge; returns at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every byte is in and every pixel is out, then lets a
  // possible trailing zero byte clear the block.
  task automatic settle();
    @(negedge clk);
    while (bytes_to_send.size() != 0 || push || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic queue_bytes(input int n, input bit first_on_head);
    for (int k = 0; k < n; k++)
      bytes_to_send.push_back(mk_byte(rand_byte(), first_on_head && k == 0));
  endtask

  task automatic pick_look();
    write_reg(CFG_ORIGIN_X, rand_origin());
    write_reg(CFG_ORIGIN_Y, rand_origin());
    write_reg(CFG_PIXEL_COLOR, 16'($urandom));
    if ($urandom_range(9) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_PIXEL_COLOR) + 1, 2**CFG_IDX_W - 1)),
                16'($urandom));
  endtask

  // Chooses a bitmap size, mostly small, and returns how many bytes to send.
  task automatic pick_geometry(output int nbytes);
    int r, w, h, stride;
    r = $urandom_range(99);
    if (r < 5) w = 0;
    else if (r < 10) w = $urandom_range(257, 511);
    else if (r < 15) w = 256;
    else w = $urandom_range(1, 40);
    r = $urandom_range(99);
    if (r < 5) h = 0;
    else if (r < 10) h = $urandom_range(257, 511);
    else if (r < 20) h = $urandom_range(7, 24);
    else h = $urandom_range(1, 6);
    // The upper data bits are not part of the size registers.
    write_reg(CFG_BITMAP_WIDTH, {7'($urandom), 9'(w)});
    write_reg(CFG_BITMAP_HEIGHT, {7'($urandom), 9'(h)});
    stride = ((w > MAX_W ? MAX_W : w) + 7) / 8;
    nbytes = stride * (h > MAX_H ? MAX_H : h);
    if (nbytes > MAX_IMAGE_BYTES) nbytes = MAX_IMAGE_BYTES;
    if (nbytes == 0) nbytes = 3;
  endtask

  task automatic run_random_image(inout int counted);
    int nbytes, r, cut, spare;
    pick_look();
    pick_geometry(nbytes);
    r = $urandom_range(99);
    if (r >= 95) begin
      // Noise: loose bytes with restart flags scattered about.
      cut = $urandom_range(1, 8);
      for (int k = 0; k < cut; k++)
        bytes_to_send.push_back(mk_byte(rand_byte(), $urandom_range(3) == 0));
      counted += cut;
    end else if (r >= 80 && r < 88 && nbytes > 1) begin
      // The size changes part way through the image.
      cut = $urandom_range(1, nbytes - 1);
      queue_bytes(cut, 1'b1);
      settle();
      pick_geometry(spare);
      queue_bytes(nbytes - cut, 1'b0);
      counted += nbytes;
    end else begin
      cut = (r >= 88) ? $urandom_range(1, nbytes) : nbytes;
      queue_bytes(cut, 1'b1);
      counted += cut;
      // Trailing bytes follow; the block drops them when the image is already complete.
      if (r >= 70 && r < 80) queue_bytes($urandom_range(1, 4), 1'b0);
    end
    settle();
  endtask

  initial begin : stimulus
    int counted;
    send_idle = 29;
    recv_idle = 63;
    @(negedge clk);
    while (rst) @(negedge clk);

    // Reset size is 8 by 8, one byte per row: a whole image, then bytes
    // past its end, then a restart.
    bytes_to_send.push_back(mk_byte(8'hFF, 1'b1));
    bytes_to_send.push_back(mk_byte(8'h00, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h01, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h80, 1'b0));
    bytes_to_send.push_back(mk_byte(8'hAA, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h55, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h81, 1'b0));
    bytes_to_send.push_back(mk_byte(8'hFE, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h6D, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h3C, 1'b1));
    settle();

    // Oversized sizes are clamped, x wraps past 0xFFFF, and writes to the
    // unused register indexes change nothing.
    write_reg(CFG_ORIGIN_X, 16'hFFFC);
    write_reg(CFG_ORIGIN_Y, 16'h8000);
    write_reg(CFG_BITMAP_WIDTH, 16'hFFFF);
    write_reg(CFG_BITMAP_HEIGHT, 16'h0101);
    write_reg(CFG_PIXEL_COLOR, 16'h0000);
    for (int k = int'(CFG_PIXEL_COLOR) + 1; k < 2**CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), 16'hFFFF);
    bytes_to_send.push_back(mk_byte(8'hFF, 1'b1));
    bytes_to_send.push_back(mk_byte(8'h01, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h80, 1'b0));
    settle();

    // A zero width, then a zero height: every byte is dropped.
    write_reg(CFG_BITMAP_WIDTH, 16'h0000);
    bytes_to_send.push_back(mk_byte(8'hFF, 1'b0));
    bytes_to_send.push_back(mk_byte(8'hFF, 1'b1));
    settle();
    write_reg(CFG_BITMAP_WIDTH, 16'h0001);
    write_reg(CFG_BITMAP_HEIGHT, 16'h0000);
    bytes_to_send.push_back(mk_byte(8'h81, 1'b1));
    settle();

    // Three bytes per row, then the width shrinks while the position sits
    // in the third column, which ends the row.
    write_reg(CFG_ORIGIN_X, 16'h7FFF);
    write_reg(CFG_ORIGIN_Y, 16'h7FFF);
    write_reg(CFG_PIXEL_COLOR, 16'hFFFF);
    write_reg(CFG_BITMAP_WIDTH, 16'd24);
    write_reg(CFG_BITMAP_HEIGHT, 16'd2);
    bytes_to_send.push_back(mk_byte(8'hFF, 1'b1));
    bytes_to_send.push_back(mk_byte(8'h0F, 1'b0));
    settle();
    write_reg(CFG_BITMAP_WIDTH, 16'd8);
    bytes_to_send.push_back(mk_byte(8'hF0, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h01, 1'b0));
    bytes_to_send.push_back(mk_byte(8'h02, 1'b0));
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle = 29;
          recv_idle = 63;
        end
        1: begin
          send_idle = 63;
          recv_idle = 29;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) run_random_image(counted);
    end

    settle();
    if (expected_pixels.size() != 0) begin
      err_count += expected_pixels.size();
      $display("tb: %0d expected pixels never came out", expected_pixels.size());
    end
    $display("tb: %0d bytes in (%0d dropped, %0d image starts), %0d pixels checked",
             bytes_accepted, bytes_ignored, images_started, pixels_checked);
    $display("tb: %0d register writes, %0d long output stalls, %0d mismatches",
             reg_writes, holds_done, err_count);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/xbm_pkg.sv
rtl/core/xbm_front.sv
rtl/core/xbm_queue.sv
rtl/core/xbm_back.sv
rtl/core/xbm_bitmap_pixel_expander_top.sv
bench/tb.sv
